>>> rtl/slr_pkg.sv
`timescale 1ns / 1ps
// Package for the subtractive lagged random generator.
// Holds constants, the state encoding, the RAM request struct and modular helpers.
// No dependencies.
package slr_pkg;

    localparam int unsigned TblDepth  = 55;
    localparam int unsigned DataW     = 30;
    localparam int unsigned AddrW     = 6;
    localparam int unsigned SeedW     = 31;
    localparam int unsigned PassW     = 2;

    localparam logic [DataW-1:0] Modulus  = 30'd1000000000;
    localparam logic [SeedW-1:0] Golden   = 31'd161803398;
    localparam logic [AddrW-1:0] LastAddr = 6'd54;
    localparam logic [AddrW-1:0] Stride   = 6'd21;
    localparam logic [AddrW-1:0] LagDist  = 6'd31;
    localparam logic [AddrW-1:0] ScatLast = 6'd53;
    localparam logic [AddrW-1:0] BackInit = 6'd31;
    localparam logic [AddrW-1:0] BackSeed = 6'd32;
    localparam logic [AddrW-1:0] FrontSeed = 6'd1;
    localparam logic [PassW-1:0] PassLast = 2'd3;
    localparam logic [SeedW-1:0] SeedReset = 31'd1;

    localparam logic [0:0] RegSeed = 1'b0;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SEED_INIT = 9'b000000010,
        ST_SEED_SCAT = 9'b000000100,
        ST_MIX_RA    = 9'b000001000,
        ST_MIX_RB    = 9'b000010000,
        ST_MIX_WR    = 9'b000100000,
        ST_DRAW_RA   = 9'b001000000,
        ST_DRAW_RB   = 9'b010000000,
        ST_DRAW_WR   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [DataW-1:0] wdata;
        logic             re;
        logic [AddrW-1:0] raddr;
    } ram_req_t;

    // (a - b) mod 1e9 for a, b below 1e9
    function automatic logic [DataW-1:0] mod_sub(input logic [DataW-1:0] a,
                                                 input logic [DataW-1:0] b);
        logic [DataW:0] sum;
        begin
            if (a >= b) begin
                sum = {1'b0, a - b};
            end else begin
                sum = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
            end
            return sum[DataW-1:0];
        end
    endfunction

    // (a + d) mod 55 for a below 55 and d below 55
    function automatic logic [AddrW-1:0] addr_add(input logic [AddrW-1:0] a,
                                                  input logic [AddrW-1:0] d);
        logic [AddrW:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, d};
            if (sum > {1'b0, LastAddr}) begin
                sum = sum - (AddrW+1)'(TblDepth);
            end
            return sum[AddrW-1:0];
        end
    endfunction

    // |seed - golden| mod 1e9; the difference stays below 2e9
    function automatic logic [DataW-1:0] seed_start(input logic [SeedW-1:0] s);
        logic [SeedW-1:0] diff;
        begin
            diff = (s >= Golden) ? (s - Golden) : (Golden - s);
            if (diff >= {1'b0, Modulus}) begin
                diff = diff - {1'b0, Modulus};
            end
            return diff[DataW-1:0];
        end
    endfunction

endpackage

>>> rtl/slr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module slr_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 55
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/slr_cfg.sv
`timescale 1ns / 1ps
// APB register block: holds the seed register.
// Depends on slr_pkg.
module slr_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [slr_pkg::SeedW-1:0]  seed_value
);

    logic [slr_pkg::SeedW-1:0] seed_reg;
    logic [slr_pkg::SeedW-1:0] seed_next;
    logic                      wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == slr_pkg::RegSeed);

    always_comb begin
        seed_next = seed_reg;
        if (wr_en) begin
            seed_next = pwdata[slr_pkg::SeedW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= slr_pkg::SeedReset;
        end else begin
            seed_reg <= seed_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == slr_pkg::RegSeed) begin
            prdata = {1'b0, seed_reg};
        end
    end

    assign pready     = 1'b1;
    assign seed_value = seed_reg;

endmodule

>>> rtl/slr_seq.sv
`timescale 1ns / 1ps
// Sequencer: seeding, mixing passes and draws over the lag table RAM,
// plus the result register. Depends on slr_pkg.
module slr_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [slr_pkg::DataW-1:0]   m_draw_value,
    input  logic [slr_pkg::SeedW-1:0]   seed_value,
    output slr_pkg::ram_req_t           ram_req,
    input  logic [slr_pkg::DataW-1:0]   ram_rdata
);

    slr_pkg::state_t state_reg, state_next;

    logic [slr_pkg::AddrW-1:0] front_reg, front_next;
    logic [slr_pkg::AddrW-1:0] back_reg, back_next;
    logic                      seeded_reg, seeded_next;
    logic [slr_pkg::DataW-1:0] cur_reg, cur_next;
    logic [slr_pkg::DataW-1:0] nxt_reg, nxt_next;
    logic [slr_pkg::DataW-1:0] hold_reg, hold_next;
    logic [slr_pkg::AddrW-1:0] walk_reg, walk_next;
    logic [slr_pkg::AddrW-1:0] step_reg, step_next;
    logic [slr_pkg::PassW-1:0] pass_reg, pass_next;
    logic                      m_valid_reg, m_valid_next;
    logic [slr_pkg::DataW-1:0] m_value_reg, m_value_next;

    logic                      accept;
    logic                      out_free;
    logic [slr_pkg::DataW-1:0] diff;

    assign s_ready  = (state_reg == slr_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign diff     = slr_pkg::mod_sub(hold_reg, ram_rdata);

    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        seeded_next  = seeded_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        hold_next    = hold_reg;
        walk_next    = walk_reg;
        step_next    = step_reg;
        pass_next    = pass_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        ram_req      = '0;

        unique case (state_reg)
            slr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_restart || !seeded_reg) begin
                        state_next = slr_pkg::ST_SEED_INIT;
                    end else begin
                        // advance both pointers and fetch the front entry now
                        front_next    = (front_reg >= 6'd55) ? 6'd1 : front_reg + 6'd1;
                        back_next     = (back_reg >= 6'd55) ? 6'd1 : back_reg + 6'd1;
                        ram_req.re    = 1'b1;
                        ram_req.raddr = (front_reg >= 6'd55) ? 6'd0 : front_reg;
                        state_next    = slr_pkg::ST_DRAW_RB;
                    end
                end
            end
            slr_pkg::ST_SEED_INIT: begin
                cur_next      = slr_pkg::seed_start(seed_value);
                ram_req.we    = 1'b1;
                ram_req.waddr = slr_pkg::LastAddr;
                ram_req.wdata = cur_next;
                nxt_next      = 30'd1;
                walk_next     = slr_pkg::Stride - 6'd1;
                step_next     = '0;
                state_next    = slr_pkg::ST_SEED_SCAT;
            end
            slr_pkg::ST_SEED_SCAT: begin
                // the entry just written is the next "cur": no read needed
                ram_req.we    = 1'b1;
                ram_req.waddr = walk_reg;
                ram_req.wdata = nxt_reg;
                nxt_next      = slr_pkg::mod_sub(cur_reg, nxt_reg);
                cur_next      = nxt_reg;
                walk_next     = slr_pkg::addr_add(walk_reg, slr_pkg::Stride);
                step_next     = step_reg + 6'd1;
                if (step_reg == slr_pkg::ScatLast) begin
                    walk_next  = '0;
                    pass_next  = '0;
                    state_next = slr_pkg::ST_MIX_RA;
                end
            end
            slr_pkg::ST_MIX_RA: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = walk_reg;
                state_next    = slr_pkg::ST_MIX_RB;
            end
            slr_pkg::ST_MIX_RB: begin
                hold_next     = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = slr_pkg::addr_add(walk_reg, slr_pkg::LagDist);
                state_next    = slr_pkg::ST_MIX_WR;
            end
            slr_pkg::ST_MIX_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = walk_reg;
                ram_req.wdata = diff;
                state_next    = slr_pkg::ST_MIX_RA;
                walk_next     = walk_reg + 6'd1;
                if (walk_reg == slr_pkg::LastAddr) begin
                    walk_next = '0;
                    pass_next = pass_reg + 2'd1;
                    if (pass_reg == slr_pkg::PassLast) begin
                        // pointers 0 and 31, already advanced for this draw
                        front_next  = slr_pkg::FrontSeed;
                        back_next   = slr_pkg::BackSeed;
                        seeded_next = 1'b1;
                        state_next  = slr_pkg::ST_DRAW_RA;
                    end
                end
            end
            slr_pkg::ST_DRAW_RA: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = front_reg - 6'd1;
                state_next    = slr_pkg::ST_DRAW_RB;
            end
            slr_pkg::ST_DRAW_RB: begin
                hold_next     = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = back_reg - 6'd1;
                state_next    = slr_pkg::ST_DRAW_WR;
            end
            slr_pkg::ST_DRAW_WR: begin
                // hold here while the previous result is still waiting
                if (out_free) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = front_reg - 6'd1;
                    ram_req.wdata = diff;
                    m_valid_next  = 1'b1;
                    m_value_next  = diff;
                    state_next    = slr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = slr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slr_pkg::ST_IDLE;
            front_reg   <= '0;
            back_reg    <= slr_pkg::BackInit;
            seeded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            walk_reg    <= '0;
            step_reg    <= '0;
            pass_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            seeded_reg  <= seeded_next;
            m_valid_reg <= m_valid_next;
            walk_reg    <= walk_next;
            step_reg    <= step_next;
            pass_reg    <= pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        hold_reg    <= hold_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_draw_value = m_value_reg;

endmodule

>>> rtl/subtractive_lagged_random.sv
`timescale 1ns / 1ps
// Top level of the subtractive lagged random generator (lag 55, modulo 1e9).
// Depends on slr_pkg, slr_ram, slr_cfg and slr_seq.
//
//  channel   | ports                               | moves
//  ----------+-------------------------------------+------------------------------
//  request   | s_valid, s_ready, s_restart         | one draw request
//  result    | m_valid, m_ready, m_draw_value      | one draw, 0 .. 999999999
//  config    | psel, penable, pwrite, paddr, ...   | seed_value at byte address 0
//
// A taken request passes through ST_DRAW_RB and ST_DRAW_WR before the result register loads
// and the block takes its next request, so draws do not overlap: the lag table RAM has
// one read port, so the two entries are fetched in turn and the difference written back.
// A request that seeds the table (first after reset, or restart set) first runs the
// seeding: one scatter write per cycle, then read-read-write for each entry of the
// four mixing passes, and then its draw.
// Reset (aresetn, synchronous) restores the pointers and clears the seeded flag; the table is
// rebuilt on the first request. A stalled result holds the next draw in its last step.
module subtractive_lagged_random (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [slr_pkg::DataW-1:0]  m_draw_value,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [slr_pkg::SeedW-1:0] seed_value;
    slr_pkg::ram_req_t         ram_req;
    logic [slr_pkg::DataW-1:0] ram_rdata;

    slr_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .seed_value (seed_value)
    );

    slr_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_draw_value (m_draw_value),
        .seed_value   (seed_value),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    slr_ram #(
        .WIDTH (slr_pkg::DataW),
        .DEPTH (slr_pkg::TblDepth)
    ) u_lag_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/slr_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the subtractive lagged random generator, bound to the top.
// Depends on slr_pkg.
module slr_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [slr_pkg::DataW-1:0]  m_draw_value
);

    // result register drops after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_draw_value))
        else $error("stalled result changed");

    // draws stay inside the modulus
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_draw_value < slr_pkg::Modulus)
        else $error("draw out of range");

    // one request at a time: the block is busy right after taking one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // no result can appear in the cycle right after a request is taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result before the table was read");

endmodule

bind subtractive_lagged_random slr_chk u_chk (.*);
